FILE: rtl/core/dshot_telemetry_rpm_decoder_assert.svh
// ------------------------------------------------------------------------
// Assertion macros for the telemetry rpm decoder
// Clocked on clk, disabled while rst is high.
// ------------------------------------------------------------------------
`ifndef DSHOT_TELEMETRY_RPM_DECODER_ASSERT_SVH
`define DSHOT_TELEMETRY_RPM_DECODER_ASSERT_SVH

// Same-cycle implication
`define DTRD_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("dtrd: same-cycle check failed");

// Next-cycle implication
`define DTRD_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("dtrd: next-cycle check failed");

`endif

FILE: rtl/core/dtrd_pkg.sv
// ------------------------------------------------------------------------
// dtrd_pkg
// Types, constants and the GCR symbol table for the telemetry rpm decoder.
// ------------------------------------------------------------------------
package dtrd_pkg;

  localparam int DIV_STEPS = 26;
  localparam int DIVISOR_W = 23;

  localparam logic [25:0] US_PER_MINUTE = 26'd60000000;
  localparam logic [15:0] PERIOD_MAX    = 16'hFF80;
  localparam logic [6:0]  POLE_PAIRS_RESET = 7'd7;

  typedef struct packed {
    logic [1:0] chan;
    logic       zero_word;
    logic       bad_sym;
    logic [3:0] hi;
    logic [3:0] mid;
    logic [3:0] lo;
    logic [3:0] chk;
  } sym_t;

  typedef struct packed {
    logic [1:0]  chan;
    logic        status;
    logic [15:0] period;
    logic        stopped;
  } info_t;

  typedef struct packed {
    info_t                 info;
    logic [DIVISOR_W-1:0]  divisor;
    logic [DIVISOR_W-1:0]  rem;
    logic [DIV_STEPS-1:0]  quo;
  } div_t;

  typedef struct packed {
    logic [1:0]  chan;
    logic        status;
    logic [15:0] period;
    logic        stopped;
    logic [25:0] rpm;
  } res_t;

  // GCR quintet to nibble; bit 4 set marks an invalid symbol
  function automatic logic [4:0] gcr_to_nibble(input logic [4:0] code);
    logic [4:0] r;
    case (code)
      5'h09:   r = 5'h09;
      5'h0A:   r = 5'h0A;
      5'h0B:   r = 5'h0B;
      5'h0D:   r = 5'h0D;
      5'h0E:   r = 5'h0E;
      5'h0F:   r = 5'h0F;
      5'h12:   r = 5'h02;
      5'h13:   r = 5'h03;
      5'h15:   r = 5'h05;
      5'h16:   r = 5'h06;
      5'h17:   r = 5'h07;
      5'h19:   r = 5'h00;
      5'h1A:   r = 5'h08;
      5'h1B:   r = 5'h01;
      5'h1D:   r = 5'h04;
      5'h1E:   r = 5'h0C;
      default: r = 5'h10;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/dshot_telemetry_rpm_decoder.sv
// Items pass the decode stages, a 26-step restoring divider and the output register.
// Throughput: one item per cycle unless stalled; the divider is fully pipelined.
// A stalled output fills a one-item skid stage, after which s_tready drops.
// Reset (rst, synchronous, active high) empties every stage; pp_reg returns to 7.
// ------------------------------------------------------------------------
// dshot_telemetry_rpm_decoder
// Decodes bidirectional motor-line eRPM telemetry words into period and rpm.
// ------------------------------------------------------------------------
module dshot_telemetry_rpm_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [1:0] channel, [22:2] raw_word, [23] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [1:0] channel_out, [17:2] period, [18] stopped,
                                 // [44:19] rpm, [47:45] zero
  output logic [0:0]  m_tuser,   // [0] status
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);
  import dtrd_pkg::*;

  logic       pole_pairs;
  logic [6:0] pp_reg;
  logic       pipe_en;
  logic       dec_valid;
  div_t       dec_data;
  logic       v  [DIV_STEPS+1];
  div_t       d  [DIV_STEPS+1];
  res_t       res;

  assign pole_pairs = (pp_reg != 7'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pp_reg <= POLE_PAIRS_RESET;
    end else if (cfg_we) begin
      pp_reg <= cfg_wdata;
    end
  end

  assign s_tready = pipe_en;

  dtrd_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .en         (pipe_en),
    .in_valid   (s_tvalid && s_tready),
    .in_chan    (s_tdata[1:0]),
    .in_word    (s_tdata[22:2]),
    .pole_pairs (pole_pairs ? pp_reg : 7'd1),
    .out_valid  (dec_valid),
    .out_data   (dec_data)
  );

  assign v[0] = dec_valid;
  assign d[0] = dec_data;

  // dividend bits enter most significant first
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    dtrd_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (pipe_en),
      .num_bit   (US_PER_MINUTE[DIV_STEPS-1-k]),
      .in_valid  (v[k]),
      .in_data   (d[k]),
      .out_valid (v[k+1]),
      .out_data  (d[k+1])
    );
  end

  dtrd_out u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v[DIV_STEPS]),
    .in_data  (d[DIV_STEPS]),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_res    (res),
    .pipe_en  (pipe_en)
  );

  assign m_tdata = {3'd0, res.rpm, res.stopped, res.period, res.chan};
  assign m_tuser = res.status;

endmodule

FILE: rtl/core/dtrd_decode.sv
// ------------------------------------------------------------------------
// dtrd_decode
// Three register stages: GCR symbol lookup, nibble check and period
// reconstruction, then divisor product period * pole_pairs.
// ------------------------------------------------------------------------
module dtrd_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [1:0]      in_chan,
  input  logic [20:0]     in_word,
  input  logic [6:0]      pole_pairs,
  output logic            out_valid,
  output dtrd_pkg::div_t  out_data
);
  import dtrd_pkg::*;

  logic        v1;
  sym_t        s1;
  logic        v2;
  info_t       s2;

  sym_t        s1_next;
  info_t       s2_next;
  div_t        s3_next;

  logic [19:0] gcr;
  logic [4:0]  g_hi, g_mid, g_lo, g_chk;
  logic [11:0] data12;
  logic        bad2;
  logic [15:0] per;
  logic [6:0]  pp_eff;

  // undo transition coding and map each quintet
  always_comb begin
    gcr   = in_word[19:0] ^ in_word[20:1];
    g_chk = gcr_to_nibble(gcr[4:0]);
    g_lo  = gcr_to_nibble(gcr[9:5]);
    g_mid = gcr_to_nibble(gcr[14:10]);
    g_hi  = gcr_to_nibble(gcr[19:15]);
    s1_next.chan      = in_chan;
    s1_next.zero_word = (in_word == 21'd0);
    s1_next.bad_sym   = g_chk[4] | g_lo[4] | g_mid[4] | g_hi[4];
    s1_next.hi        = g_hi[3:0];
    s1_next.mid       = g_mid[3:0];
    s1_next.lo        = g_lo[3:0];
    s1_next.chk       = g_chk[3:0];
  end

  // check nibble is the inverted xor of the data nibbles
  always_comb begin
    data12 = {s1.hi, s1.mid, s1.lo};
    bad2   = s1.zero_word | s1.bad_sym | ((~(s1.hi ^ s1.mid ^ s1.lo)) != s1.chk);
    per    = bad2 ? 16'd0 : ({7'd0, data12[8:0]} << data12[11:9]);
    s2_next.chan    = s1.chan;
    s2_next.status  = bad2;
    s2_next.period  = per;
    s2_next.stopped = !bad2 && ((per == 16'd0) || (per == PERIOD_MAX));
  end

  // zero pole pairs count as one
  always_comb begin
    pp_eff = (pole_pairs == 7'd0) ? 7'd1 : pole_pairs;
    s3_next.info    = s2;
    s3_next.divisor = DIVISOR_W'(s2.period) * DIVISOR_W'(pp_eff);
    s3_next.rem     = '0;
    s3_next.quo     = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1       <= s1_next;
      s2       <= s2_next;
      out_data <= s3_next;
    end
  end

endmodule

FILE: rtl/core/dtrd_div_step.sv
// ------------------------------------------------------------------------
// dtrd_div_step
// One registered restoring-division step: shift in the next dividend bit,
// subtract the divisor where it fits, shift the quotient bit in.
// ------------------------------------------------------------------------
module dtrd_div_step (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            num_bit,
  input  logic            in_valid,
  input  dtrd_pkg::div_t  in_data,
  output logic            out_valid,
  output dtrd_pkg::div_t  out_data
);
  import dtrd_pkg::*;

  logic [DIVISOR_W:0]   sh;
  logic [DIVISOR_W-1:0] diff;
  logic                 fits;
  div_t                 step_next;

  // where the divisor fits the difference is below the divisor
  always_comb begin
    sh   = {in_data.rem, num_bit};
    diff = sh[DIVISOR_W-1:0] - in_data.divisor;
    fits = (sh >= {1'b0, in_data.divisor});
    step_next         = in_data;
    step_next.rem     = fits ? diff : sh[DIVISOR_W-1:0];
    step_next.quo     = {in_data.quo[DIV_STEPS-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= step_next;
    end
  end

endmodule

FILE: rtl/core/dtrd_out.sv
// ------------------------------------------------------------------------
// dtrd_out
// Output register with a one-item skid stage. Forms the final rpm and
// holds the pipeline only while the skid stage is occupied.
// ------------------------------------------------------------------------
module dtrd_out (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  dtrd_pkg::div_t  in_data,
  input  logic            m_tready,
  output logic            m_tvalid,
  output dtrd_pkg::res_t  m_res,
  output logic            pipe_en
);
  import dtrd_pkg::*;

  logic  skid_valid;
  res_t  skid;
  res_t  res_next;
  logic  out_free;

  // no rotation or a bad word gives rpm zero
  always_comb begin
    res_next.chan    = in_data.info.chan;
    res_next.status  = in_data.info.status;
    res_next.period  = in_data.info.period;
    res_next.stopped = in_data.info.stopped;
    res_next.rpm     = (in_data.info.status | in_data.info.stopped) ? 26'd0 : in_data.quo;
  end

  assign out_free = !m_tvalid || m_tready;
  assign pipe_en  = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid   <= in_valid;
      end
    end else if (in_valid && pipe_en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      m_res <= skid_valid ? skid : res_next;
    end else if (pipe_en) begin
      skid  <= res_next;
    end
  end

endmodule

FILE: rtl/core/dtrd_checker.sv
// ------------------------------------------------------------------------
// dtrd_checker
// Port-level checks on the telemetry rpm decoder, bound to the top level.
// ------------------------------------------------------------------------
`include "dshot_telemetry_rpm_decoder_assert.svh"

module dtrd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // input side only backs up behind a held result
  `DTRD_ASSERT_NOW(a_ready_low_only_when_full, !s_tready, m_tvalid)

  // a bad word carries no period, stop flag or rpm
  `DTRD_ASSERT_NOW(a_bad_word_clear, m_tvalid && m_tuser[0], m_tdata[44:2] == 43'd0)

  // no rotation gives rpm zero
  `DTRD_ASSERT_NOW(a_stopped_rpm_zero, m_tvalid && m_tdata[18], m_tdata[44:19] == 26'd0)

  // stop flag follows the period on good words
  `DTRD_ASSERT_NOW(a_stop_matches_period, m_tvalid && !m_tuser[0], m_tdata[18] == ((m_tdata[17:2] == 16'd0) || (m_tdata[17:2] == 16'hFF80)))

  // a held result stays put
  `DTRD_ASSERT_NEXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind dshot_telemetry_rpm_decoder dtrd_checker u_dtrd_checker (.*);

FILE: test/telemetry_decode_checker.sv
// ------------------------------------------------------------------------
// telemetry_decode_checker
// Watches the telemetry decoder's input, output and register port. Every
// accepted telemetry word is decoded here into the report it should yield,
// using the pole-pair setting in force at that edge. Reports from the block
// are compared field by field, in order, against these expectations.
// ------------------------------------------------------------------------
module telemetry_decode_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // [1:0] channel, [22:2] raw_word, [23] zero
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,   // [1:0] channel_out, [17:2] period, [18] stopped,
                                 // [44:19] rpm, [47:45] zero
  input  logic [0:0]  m_tuser,   // [0] status
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  output int          mismatches,
  output int          reports_pending,
  output int          reports_seen,
  output int          rejected_seen,
  output int          stopped_seen
);
  import dtrd_pkg::*;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;
  localparam int   REPORT_MAX = 10;

  res_t       expected_reports[$];
  logic [6:0] pole_pairs_q;

  // Quintet to {valid, nibble}
  function automatic logic [4:0] quintet_nibble(input logic [4:0] q);
    logic [4:0] r;
    case (q)
      5'h19: r = {1'b1, 4'h0};
      5'h1B: r = {1'b1, 4'h1};
      5'h12: r = {1'b1, 4'h2};
      5'h13: r = {1'b1, 4'h3};
      5'h1D: r = {1'b1, 4'h4};
      5'h15: r = {1'b1, 4'h5};
      5'h16: r = {1'b1, 4'h6};
      5'h17: r = {1'b1, 4'h7};
      5'h1A: r = {1'b1, 4'h8};
      5'h09: r = {1'b1, 4'h9};
      5'h0A: r = {1'b1, 4'hA};
      5'h0B: r = {1'b1, 4'hB};
      5'h1E: r = {1'b1, 4'hC};
      5'h0D: r = {1'b1, 4'hD};
      5'h0E: r = {1'b1, 4'hE};
      5'h0F: r = {1'b1, 4'hF};
      default: r = 5'h00;
    endcase
    return r;
  endfunction

  function automatic res_t decode_telemetry(input logic [1:0] chan, input logic [20:0] word,
                                            input logic [6:0] pole_pairs);
    res_t        r;
    logic [19:0] gcr;
    logic [4:0]  q_chk, q_lo, q_mid, q_hi;
    logic [11:0] data;
    logic [3:0]  parity;
    int unsigned per, pp;
    r = '0;
    r.chan = chan;
    r.status = STATUS_BAD;
    // undo the transition coding
    gcr = word[19:0] ^ word[20:1];
    q_chk = quintet_nibble(gcr[4:0]);
    q_lo  = quintet_nibble(gcr[9:5]);
    q_mid = quintet_nibble(gcr[14:10]);
    q_hi  = quintet_nibble(gcr[19:15]);
    data = {q_hi[3:0], q_mid[3:0], q_lo[3:0]};
    parity = ~(q_hi[3:0] ^ q_mid[3:0] ^ q_lo[3:0]);
    if (word != '0 && q_chk[4] && q_lo[4] && q_mid[4] && q_hi[4] && parity == q_chk[3:0]) begin
      r.status = STATUS_OK;
      per = data[8:0];
      per = per << data[11:9];
      r.period = per[15:0];
      if (per == 0 || per == PERIOD_MAX) begin
        r.stopped = 1'b1;
      end else begin
        pp = (pole_pairs == '0) ? 1 : pole_pairs;
        r.rpm = 26'((US_PER_MINUTE / per) / pp);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    res_t got, want;
    if (rst) begin
      expected_reports.delete();
      pole_pairs_q    <= POLE_PAIRS_RESET;
      mismatches      <= 0;
      reports_pending <= 0;
      reports_seen    <= 0;
      rejected_seen   <= 0;
      stopped_seen    <= 0;
    end else begin
      // check the outgoing report before queueing the incoming word
      if (m_tvalid && m_tready) begin
        got.chan    = m_tdata[1:0];
        got.status  = m_tuser[0];
        got.period  = m_tdata[17:2];
        got.stopped = m_tdata[18];
        got.rpm     = m_tdata[44:19];
        reports_seen  <= reports_seen + 1;
        rejected_seen <= rejected_seen + (got.status == STATUS_BAD);
        stopped_seen  <= stopped_seen + (got.stopped == 1'b1);
        if (expected_reports.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < REPORT_MAX)
            $display("[%0t] unexpected report: chan=%0d status=%0d period=%0d stopped=%0d rpm=%0d",
                     $time, got.chan, got.status, got.period, got.stopped, got.rpm);
        end else begin
          want = expected_reports.pop_front();
          if (got.chan !== want.chan || got.status !== want.status ||
              got.period !== want.period || got.stopped !== want.stopped ||
              got.rpm !== want.rpm) begin
            mismatches <= mismatches + 1;
            if (mismatches < REPORT_MAX) begin
              $display("[%0t] report mismatch, expected: chan=%0d status=%0d period=%0d stopped=%0d rpm=%0d",
                       $time, want.chan, want.status, want.period, want.stopped, want.rpm);
              $display("[%0t] report mismatch, actual:   chan=%0d status=%0d period=%0d stopped=%0d rpm=%0d",
                       $time, got.chan, got.status, got.period, got.stopped, got.rpm);
            end
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_reports.push_back(decode_telemetry(s_tdata[1:0], s_tdata[22:2], pole_pairs_q));
      if (cfg_we)
        pole_pairs_q <= cfg_wdata;
      reports_pending <= expected_reports.size();
    end
  end

endmodule

FILE: test/tb.sv
// ------------------------------------------------------------------------
// tb
// Drives telemetry words into the rpm decoder: a directed set covering
// zero words, bad symbols, check failures, stopped periods and pole-pair
// extremes, then random phases with sender gaps and receiver stalls under
// several pole-pair settings. The checker beside the block scores reports.
// ------------------------------------------------------------------------
module tb;

  typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 300;
  localparam int PHASES       = 6;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int NO_SLOT      = -1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_wdata = '0;

  int mismatches, reports_pending, reports_seen, rejected_seen, stopped_seen;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int words_sent = 0;
  int cycles = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;

  always #10 clk = ~clk;

  dshot_telemetry_rpm_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  telemetry_decode_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .reports_pending (reports_pending),
    .reports_seen    (reports_seen),
    .rejected_seen   (rejected_seen),
    .stopped_seen    (stopped_seen)
  );

  // long receiver hold-off, counted here once requested
  always @(posedge clk) begin
    if (hold_left != 0)
      hold_left <= hold_left - 1;
    else if (hold_req)
      hold_left <= HOLD_CYCLES;
  end

  always @(posedge clk) begin
    if (rst)
      m_tready <= 1'b0;
    else
      m_tready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [4:0] gcr_code(input logic [3:0] nib);
    logic [4:0] q;
    case (nib)
      4'h0: q = 5'h19;
      4'h1: q = 5'h1B;
      4'h2: q = 5'h12;
      4'h3: q = 5'h13;
      4'h4: q = 5'h1D;
      4'h5: q = 5'h15;
      4'h6: q = 5'h16;
      4'h7: q = 5'h17;
      4'h8: q = 5'h1A;
      4'h9: q = 5'h09;
      4'hA: q = 5'h0A;
      4'hB: q = 5'h0B;
      4'hC: q = 5'h1E;
      4'hD: q = 5'h0D;
      4'hE: q = 5'h0E;
      default: q = 5'h0F;
    endcase
    return q;
  endfunction

  // the sixteen quintets that map to no nibble
  function automatic logic [4:0] illegal_code(input logic [3:0] idx);
    logic [4:0] q;
    case (idx)
      4'h9: q = 5'h0C;
      4'hA: q = 5'h10;
      4'hB: q = 5'h11;
      4'hC: q = 5'h14;
      4'hD: q = 5'h18;
      4'hE: q = 5'h1C;
      4'hF: q = 5'h1F;
      default: q = {1'b0, idx};
    endcase
    return q;
  endfunction

  // Encode exponent and mantissa into a line word; flip the check nibble or
  // plant an illegal quintet in one slot to make broken words.
  function automatic logic [20:0] line_word(input logic [2:0] expo, input logic [8:0] mant,
                                            input logic [3:0] chk_flip, input int bad_slot,
                                            input logic [3:0] bad_idx, input logic top);
    logic [11:0] data;
    logic [3:0]  chk;
    logic [20:0] gcr;
    logic [20:0] w;
    data = {expo, mant};
    chk = ~(data[11:8] ^ data[7:4] ^ data[3:0]) ^ chk_flip;
    gcr = {top, gcr_code(data[11:8]), gcr_code(data[7:4]), gcr_code(data[3:0]), gcr_code(chk)};
    if (bad_slot != NO_SLOT)
      gcr[5*bad_slot +: 5] = illegal_code(bad_idx);
    // apply the transition coding in reverse, top bit down
    w[20] = gcr[20];
    for (int i = 19; i >= 0; i--)
      w[i] = gcr[i] ^ w[i+1];
    return w;
  endfunction

  task automatic send_word(input logic [1:0] ch, input logic [20:0] w);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, w, ch};
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    words_sent++;
  endtask

  task automatic send_valid(input logic [1:0] ch, input logic [2:0] expo, input logic [8:0] mant);
    send_word(ch, line_word(expo, mant, 4'h0, NO_SLOT, 4'h0, 1'b0));
  endtask

  // hold the sender until every report has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (reports_pending != 0)
      @(posedge clk);
  endtask

  task automatic set_pole_pairs(input logic [6:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_random_word();
    logic [1:0] ch;
    logic [2:0] expo;
    logic [8:0] mant;
    int pick;
    ch   = $urandom_range(3);
    expo = $urandom_range(7);
    case ($urandom_range(9))
      0: mant = 9'd0;
      1: mant = 9'd511;
      2: mant = $urandom_range(1, 3);
      default: mant = $urandom_range(511);
    endcase
    pick = $urandom_range(99);
    if (pick < 65)
      send_word(ch, line_word(expo, mant, 4'h0, NO_SLOT, 4'h0, $urandom_range(1)));
    else if (pick < 75)
      send_word(ch, line_word(expo, mant, $urandom_range(1, 15), NO_SLOT, 4'h0,
                              $urandom_range(1)));
    else if (pick < 85)
      send_word(ch, line_word(expo, mant, 4'h0, $urandom_range(3), $urandom_range(15),
                              $urandom_range(1)));
    else if (pick < 97)
      send_word(ch, $urandom_range(21'h1FFFFF));
    else
      send_word(ch, '0);
  endtask

  initial begin : stimulus
    idle_mode_t mode;
    logic [6:0] pp;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words at the reset pole-pair count
    send_word(2'd0, 21'h000000);
    send_word(2'd3, 21'h1FFFFF);
    send_valid(2'd1, 3'd0, 9'd1);
    send_valid(2'd2, 3'd0, 9'd0);
    send_valid(2'd3, 3'd5, 9'd0);
    send_word(2'd0, line_word(3'd7, 9'd511, 4'h0, NO_SLOT, 4'h0, 1'b1));
    send_valid(2'd1, 3'd6, 9'd511);
    send_valid(2'd2, 3'd7, 9'd510);
    send_word(2'd3, line_word(3'd2, 9'd100, 4'h1, NO_SLOT, 4'h0, 1'b0));
    send_word(2'd0, line_word(3'd4, 9'd333, 4'hF, NO_SLOT, 4'h0, 1'b1));
    send_word(2'd1, line_word(3'd1, 9'd42, 4'h0, 0, 4'h0, 1'b0));
    send_word(2'd2, line_word(3'd1, 9'd42, 4'h0, 1, 4'hF, 1'b1));
    send_word(2'd3, line_word(3'd1, 9'd42, 4'h0, 2, 4'h9, 1'b0));
    send_word(2'd0, line_word(3'd1, 9'd42, 4'h0, 3, 4'hC, 1'b1));
    send_word(2'd1, 21'h0AAAAA);
    send_word(2'd2, 21'h155555);
    set_pole_pairs(7'd0);
    send_valid(2'd0, 3'd0, 9'd1);
    send_valid(2'd3, 3'd3, 9'd200);
    set_pole_pairs(7'd127);
    send_valid(2'd1, 3'd0, 9'd1);
    send_valid(2'd2, 3'd2, 9'd77);
    set_pole_pairs(7'd64);
    send_valid(2'd0, 3'd0, 9'd1);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: pp = 7'd1;
        1: pp = 7'd64;
        2: pp = 7'd0;
        3: pp = 7'd127;
        4: pp = 7'd7;
        default: pp = $urandom_range(1, 64);
      endcase
      set_pole_pairs(pp);
      mode = idle_mode_t'(p % 4);
      src_idle_pct  <= (mode == IDLE_SRC) ? 85 : (mode == IDLE_BOTH) ? 27 : 0;
      snk_stall_pct <= (mode == IDLE_SNK) ? 85 : (mode == IDLE_BOTH) ? 27 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // stall the output for a long stretch and keep offering words
        if (p == 0 && n == 60) begin
          s_tvalid <= 1'b0;
          hold_req <= 1'b1;
          @(posedge clk);
          hold_req <= 1'b0;
        end
        send_random_word();
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d telemetry words, got %0d reports (%0d rejected, %0d stopped).",
             words_sent, reports_seen, rejected_seen, stopped_seen);
    $display("Pole pairs swept over 0, 1, 7, 64, 127 with sender gaps and receiver stalls.");
    if (mismatches == 0 && reports_pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: dshot_telemetry_rpm_decoder.f
+incdir+rtl/core
rtl/core/dtrd_pkg.sv
rtl/core/dtrd_decode.sv
rtl/core/dtrd_div_step.sv
rtl/core/dtrd_out.sv
rtl/core/dshot_telemetry_rpm_decoder.sv
rtl/core/dtrd_checker.sv
test/telemetry_decode_checker.sv
test/tb.sv
